// ----- rtl/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising clock edge outside reset
`define LMCPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising clock edge, reset included
`define LMCPR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lmcpr_pkg.sv -----
// types, colors, font and arithmetic helpers of the led matrix clock pixel renderer
// no dependencies
package lmcpr_pkg;

   typedef struct packed {
      logic [7:0]        strip_position;
      logic signed [7:0] temp_whole;
      logic [7:0]        air_level;
      logic [4:0]        hours;
      logic [5:0]        minutes;
      logic [5:0]        seconds;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] position_out;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_beat_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   typedef struct packed {
      logic [7:0] position;
      rgb_type    color;
   } pixel_type;

   localparam logic [7:0] BRIGHTNESS_RESET = 8'd5;

   localparam rgb_type COLOR_OFF    = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
   localparam rgb_type COLOR_DECOR  = '{red: 8'd0,   green: 8'd0,   blue: 8'd30};
   localparam rgb_type COLOR_GREEN  = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
   localparam rgb_type COLOR_YELLOW = '{red: 8'd255, green: 8'd255, blue: 8'd0};
   localparam rgb_type COLOR_ORANGE = '{red: 8'd255, green: 8'd128, blue: 8'd0};
   localparam rgb_type COLOR_RED    = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
   localparam rgb_type COLOR_COLD   = '{red: 8'd0,   green: 8'd100, blue: 8'd255};
   localparam rgb_type COLOR_MILD   = '{red: 8'd200, green: 8'd255, blue: 8'd200};
   localparam rgb_type COLOR_TIME   = '{red: 8'd200, green: 8'd200, blue: 8'd255};
   localparam rgb_type COLOR_WHITE  = '{red: 8'd255, green: 8'd255, blue: 8'd255};

   localparam int unsigned FONT_DIGITS = 10;
   localparam int unsigned FONT_ROWS   = 7;

   // bit 2 is the left column of the glyph
   localparam logic [2:0] FONT [FONT_DIGITS][FONT_ROWS] = '{
      '{3'd7, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd7},
      '{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
      '{3'd7, 3'd1, 3'd1, 3'd7, 3'd4, 3'd4, 3'd7},
      '{3'd7, 3'd1, 3'd1, 3'd7, 3'd1, 3'd1, 3'd7},
      '{3'd5, 3'd5, 3'd5, 3'd7, 3'd1, 3'd1, 3'd1},
      '{3'd7, 3'd4, 3'd4, 3'd7, 3'd1, 3'd1, 3'd7},
      '{3'd7, 3'd4, 3'd4, 3'd7, 3'd5, 3'd5, 3'd7},
      '{3'd7, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
      '{3'd7, 3'd5, 3'd5, 3'd7, 3'd5, 3'd5, 3'd7},
      '{3'd7, 3'd5, 3'd5, 3'd7, 3'd1, 3'd1, 3'd7}
   };

   // glyph row for matrix rows 1 to 7, blank for row 0 and for digits above 9
   function automatic logic [2:0] font_row(input logic [3:0] digit, input logic [2:0] row);
      logic [2:0] bits;
      bits = 3'd0;
      if (digit <= 4'd9 && row != 3'd0) begin
         bits = FONT[digit][row - 3'd1];
      end
      return bits;
   endfunction

   // exact floor(v / 10) for any 8 bit value
   function automatic logic [4:0] div10(input logic [7:0] v);
      logic [15:0] prod;
      prod = 16'(v) * 16'd205;
      return prod[15:11];
   endfunction

   // exact floor(x / 255) for any product of two 8 bit values
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = 17'(x) + 17'(x[15:8]) + 17'd1;
      return sum[15:8];
   endfunction

endpackage

// ----- rtl/lmcpr_glyph.sv -----
// decode and font stages: strip position and readings to unscaled pixel color
// depends on lmcpr_pkg and assert_macros.svh
`include "assert_macros.svh"

module lmcpr_glyph import lmcpr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_beat_type in_beat,
   output logic         out_valid,
   input  logic         out_ready,
   output pixel_type    out_pixel
);

   localparam logic [4:0] COL_AIR      = 5'd2;
   localparam logic [4:0] COL_TENS     = 5'd6;
   localparam logic [4:0] COL_ONES     = 5'd10;
   localparam logic [4:0] COL_HOUR_HI  = 5'd15;
   localparam logic [4:0] COL_HOUR_LO  = 5'd19;
   localparam logic [4:0] COL_COLON    = 5'd22;
   localparam logic [4:0] COL_MIN_HI   = 5'd23;
   localparam logic [4:0] COL_MIN_LO   = 5'd27;
   localparam logic [4:0] GLYPH_SPAN   = 5'd2;

   typedef struct packed {
      logic [7:0] pos;
      logic [4:0] col;
      logic [2:0] row;
      logic [3:0] air_digit;
      rgb_type    air_color;
      logic [7:0] temp_mag;
      logic       temp_neg;
      logic [3:0] temp_q;
      rgb_type    temp_color;
      logic [4:0] hours;
      logic [1:0] hours_q;
      logic [5:0] minutes;
      logic [2:0] minutes_q;
      logic       sec_even;
   } stage1_type;

   stage1_type s1_in, s1_ff;
   logic       s1_valid_ff;
   pixel_type  s2_in, s2_ff;
   logic       s2_valid_ff;
   logic       ready1, ready2;

   assign ready2   = !s2_valid_ff || out_ready;
   assign ready1   = !s1_valid_ff || ready2;
   assign in_ready = ready1;

   // stage 1: geometry, magnitudes, quotients and reading colors
   always_comb begin
      logic signed [7:0] t;
      t               = in_beat.temp_whole;
      s1_in.pos       = in_beat.strip_position;
      s1_in.col       = in_beat.strip_position[7:3];
      s1_in.row       = in_beat.strip_position[3] ? ~in_beat.strip_position[2:0]
                                                   : in_beat.strip_position[2:0];
      s1_in.air_digit = (in_beat.air_level > 8'd9) ? 4'd9 : in_beat.air_level[3:0];
      priority if (in_beat.air_level <= 8'd2) begin
         s1_in.air_color = COLOR_GREEN;
      end else if (in_beat.air_level == 8'd3) begin
         s1_in.air_color = COLOR_YELLOW;
      end else if (in_beat.air_level == 8'd4) begin
         s1_in.air_color = COLOR_ORANGE;
      end else begin
         s1_in.air_color = COLOR_RED;
      end
      s1_in.temp_neg = t[7];
      s1_in.temp_mag = t[7] ? 8'(-t) : 8'(t);
      s1_in.temp_q   = 4'(div10(s1_in.temp_mag));
      priority if (t < 8'sd10) begin
         s1_in.temp_color = COLOR_COLD;
      end else if (t <= 8'sd30) begin
         s1_in.temp_color = COLOR_MILD;
      end else begin
         s1_in.temp_color = COLOR_ORANGE;
      end
      s1_in.hours     = in_beat.hours;
      s1_in.hours_q   = 2'(div10(8'(in_beat.hours)));
      s1_in.minutes   = in_beat.minutes;
      s1_in.minutes_q = 3'(div10(8'(in_beat.minutes)));
      s1_in.sec_even  = !in_beat.seconds[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && in_valid) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: digit select, font lookup and color
   always_comb begin
      logic [3:0] temp_r, tens_mag, hours_r, minutes_r, digit;
      logic [1:0] offset;
      logic       tens_draw, ones_draw, draw, decor;
      logic [2:0] bits;
      rgb_type    hue;
      temp_r    = 4'(s1_ff.temp_mag - 8'(s1_ff.temp_q) * 8'd10);
      tens_mag  = (s1_ff.temp_q >= 4'd10) ? s1_ff.temp_q - 4'd10 : s1_ff.temp_q;
      tens_draw = !(s1_ff.temp_neg && tens_mag != 4'd0);
      ones_draw = !(s1_ff.temp_neg && temp_r != 4'd0);
      hours_r   = 4'(s1_ff.hours - 5'(s1_ff.hours_q) * 5'd10);
      minutes_r = 4'(s1_ff.minutes - 6'(s1_ff.minutes_q) * 6'd10);
      digit     = 4'd0;
      offset    = 2'd0;
      draw      = 1'b0;
      hue       = COLOR_OFF;
      decor     = (s1_ff.col == 5'd0) || (s1_ff.col == 5'd1) || (s1_ff.col == 5'd5) ||
                  (s1_ff.col == 5'd13) || (s1_ff.col == 5'd14) ||
                  (s1_ff.col == 5'd30) || (s1_ff.col == 5'd31);
      s2_in.position = s1_ff.pos;
      s2_in.color    = COLOR_OFF;
      priority if (s1_ff.row == 3'd0) begin
         if (decor) begin
            s2_in.color = COLOR_DECOR;
         end
      end else if (s1_ff.col >= COL_AIR && s1_ff.col <= COL_AIR + GLYPH_SPAN) begin
         digit  = s1_ff.air_digit;
         offset = 2'(s1_ff.col - COL_AIR);
         draw   = 1'b1;
         hue    = s1_ff.air_color;
      end else if (s1_ff.col >= COL_TENS && s1_ff.col <= COL_TENS + GLYPH_SPAN) begin
         digit  = tens_mag;
         offset = 2'(s1_ff.col - COL_TENS);
         draw   = tens_draw;
         hue    = s1_ff.temp_color;
      end else if (s1_ff.col >= COL_ONES && s1_ff.col <= COL_ONES + GLYPH_SPAN) begin
         digit  = temp_r;
         offset = 2'(s1_ff.col - COL_ONES);
         draw   = ones_draw;
         hue    = s1_ff.temp_color;
      end else if (s1_ff.col == COL_COLON) begin
         if (s1_ff.sec_even && (s1_ff.row == 3'd2 || s1_ff.row == 3'd4)) begin
            s2_in.color = COLOR_WHITE;
         end
      end else if (s1_ff.col >= COL_HOUR_HI && s1_ff.col <= COL_HOUR_HI + GLYPH_SPAN) begin
         digit  = 4'(s1_ff.hours_q);
         offset = 2'(s1_ff.col - COL_HOUR_HI);
         draw   = 1'b1;
         hue    = COLOR_TIME;
      end else if (s1_ff.col >= COL_HOUR_LO && s1_ff.col <= COL_HOUR_LO + GLYPH_SPAN) begin
         digit  = hours_r;
         offset = 2'(s1_ff.col - COL_HOUR_LO);
         draw   = 1'b1;
         hue    = COLOR_TIME;
      end else if (s1_ff.col >= COL_MIN_HI && s1_ff.col <= COL_MIN_HI + GLYPH_SPAN) begin
         digit  = 4'(s1_ff.minutes_q);
         offset = 2'(s1_ff.col - COL_MIN_HI);
         draw   = 1'b1;
         hue    = COLOR_TIME;
      end else if (s1_ff.col >= COL_MIN_LO && s1_ff.col <= COL_MIN_LO + GLYPH_SPAN) begin
         digit  = minutes_r;
         offset = 2'(s1_ff.col - COL_MIN_LO);
         draw   = 1'b1;
         hue    = COLOR_TIME;
      end else begin
         draw = 1'b0;
      end
      bits = font_row(digit, s1_ff.row);
      if (draw && bits[2'd2 - offset]) begin
         s2_in.color = hue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_pixel = s2_ff;

   `LMCPR_ASSERT(a_glyph_advance, clock, reset, s1_valid_ff && ready2 |=> s2_valid_ff && (s2_ff.position == $past(s1_ff.pos)), "stage 1 beat lost on the way to stage 2")
   `LMCPR_ASSERT(a_glyph_hold, clock, reset, s1_valid_ff && !ready2 |=> s1_valid_ff && $stable(s1_ff), "stalled stage 1 beat changed")

endmodule

// ----- rtl/led_matrix_clock_pixel_renderer_unit.sv -----
// led matrix clock pixel renderer, top level
// depends on lmcpr_pkg, lmcpr_glyph and assert_macros.svh
//
// Gives the color of one LED of an 8x32 serpentine clock matrix per beat: a new
// position and set of readings is taken every clock unless the result side stalls,
// and its color passes four register stages (column and quotient decode, font
// lookup and color select, brightness multiply, divide by 255). Stalls on the result
// side hold the pipeline without losing beats; bubbles pass through. Brightness
// resets to 5; the user must write it through the csr port while idle (unenforced).
`include "assert_macros.svh"

module led_matrix_clock_pixel_renderer_unit import lmcpr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_beat_type req_beat,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_beat_type rsp_beat,
   input  logic         csr_wr_en,
   input  logic [7:0]   csr_wr_data
);

   logic [7:0]   brightness_ff;
   logic         in_ready;
   logic         px_valid;
   pixel_type    px;
   logic         ready3, ready4;
   logic         s3_valid_ff;
   logic [7:0]   s3_pos_ff;
   logic [15:0]  s3_red_ff, s3_green_ff, s3_blue_ff;
   logic [15:0]  s3_red_in, s3_green_in, s3_blue_in;
   logic         rsp_valid_ff;
   rsp_beat_type rsp_beat_ff, rsp_beat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         brightness_ff <= BRIGHTNESS_RESET;
      end else if (csr_wr_en) begin
         brightness_ff <= csr_wr_data;
      end
   end

   assign ready4    = !rsp_valid_ff || !rsp_stall;
   assign ready3    = !s3_valid_ff || ready4;
   assign req_stall = !in_ready;

   lmcpr_glyph u_glyph (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_beat   (req_beat),
      .out_valid (px_valid),
      .out_ready (ready3),
      .out_pixel (px)
   );

   // stage 3: brightness multiply
   assign s3_red_in   = 16'(px.color.red) * 16'(brightness_ff);
   assign s3_green_in = 16'(px.color.green) * 16'(brightness_ff);
   assign s3_blue_in  = 16'(px.color.blue) * 16'(brightness_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (ready3) begin
         s3_valid_ff <= px_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && px_valid) begin
         s3_pos_ff   <= px.position;
         s3_red_ff   <= s3_red_in;
         s3_green_ff <= s3_green_in;
         s3_blue_ff  <= s3_blue_in;
      end
   end

   // stage 4: divide by 255 into the output register
   always_comb begin
      rsp_beat_in.position_out = s3_pos_ff;
      rsp_beat_in.red          = div255(s3_red_ff);
      rsp_beat_in.green        = div255(s3_green_ff);
      rsp_beat_in.blue         = div255(s3_blue_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready4) begin
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready4 && s3_valid_ff) begin
         rsp_beat_ff <= rsp_beat_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   `LMCPR_ASSERT(a_scale_hold, clock, reset, s3_valid_ff && !ready4 |=> s3_valid_ff && $stable(s3_pos_ff), "stalled product stage beat changed")
   `LMCPR_ASSERT(a_scale_advance, clock, reset, s3_valid_ff && ready4 |=> rsp_valid && (rsp_beat.position_out == $past(s3_pos_ff)), "product stage beat lost on the way out")
   `LMCPR_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid && !s3_valid_ff, "pipeline not empty after reset")

endmodule
